### hdl/harmonic_bond_force_core_macros.svh
// Assertion macros for the harmonic bond force core.
// Included by the RTL files that carry concurrent assertions; needs no package.
`ifndef HARMONIC_BOND_FORCE_CORE_MACROS_SVH
`define HARMONIC_BOND_FORCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HBF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("hbf assertion failed");
`define HBF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("hbf assertion failed");
`else
`define HBF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HBF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/hbf_pkg.sv
// Package of the harmonic bond force core: widths, word types and register codes.
// Used by every module of the core; depends on nothing.
`default_nettype none
package hbf_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 32;
  localparam int K_W        = 32;
  localparam int R0_W       = 31;
  localparam int BOX_W      = 31;
  localparam int WRAP_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;
  localparam int OUT_W      = 48;

  localparam int D_W      = POS_W + 1;
  localparam int MAG_W    = POS_W;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int R_W      = SUM_W / 2;
  localparam int DELTA_W  = R_W + 1;
  localparam int DM_W     = R_W;
  localparam int P1_W     = K_W + DM_W;
  localparam int P1_LO_W  = (P1_W + 1) / 2;
  localparam int P1_HI_W  = P1_W - P1_LO_W;
  localparam int PPLO_W   = P1_LO_W + MAG_W;
  localparam int PPHI_W   = P1_HI_W + MAG_W;
  localparam int NUM_W    = P1_W + MAG_W + 1;
  localparam int E1_W     = 2 * DM_W;
  localparam int E1_LO_W  = E1_W / 2;
  localparam int E1_HI_W  = E1_W - E1_LO_W;
  localparam int ELO_W    = E1_LO_W + K_W;
  localparam int EHI_W    = E1_HI_W + K_W;
  localparam int EFULL_W  = E1_W + K_W;
  localparam int Q_W      = OUT_W;
  localparam int DEN_W    = R_W + FRAC_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [OUT_W-1:0] FORCE_POS_CAP = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] FORCE_NEG_CAP = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WRAP_ENABLE,
    CFG_BOX_LEN_X,
    CFG_BOX_LEN_Y,
    CFG_BOX_LEN_Z
  } cfg_idx_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_a_z;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] pos_b_z;
    logic [K_W-1:0]          stiffness;
    logic [R0_W-1:0]         rest_length;
  } in_word_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic [OUT_W-1:0]        energy_term;
  } out_word_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] d;
    logic [K_W-1:0]      k;
    logic [R0_W-1:0]     r0;
  } bond_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [DEN_W-1:0]      den;
    logic [2:0]            kill;
    logic [2:0]            neg;
    logic [OUT_W-1:0]      energy;
  } div_in_t;

  typedef struct packed {
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          ovf;
    logic [2:0]          kill;
    logic [2:0]          neg;
    logic [OUT_W-1:0]    energy;
  } div_out_t;

endpackage
`default_nettype wire

### hdl/hbf_front.sv
// Front end: configuration registers, word acceptance and wrapped displacement.
// Depends on hbf_pkg; feeds hbf_fifo.
`default_nettype none
module hbf_front import hbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output bond_t                 q_data
);

  logic [WRAP_W-1:0]       wrap_r;
  logic [BOX_W-1:0]        box_r [3];
  logic signed [POS_W-1:0] pos_a [3];
  logic signed [POS_W-1:0] pos_b [3];
  logic signed [D_W:0]     lim_s;
  logic signed [D_W:0]     v_s [3];
  logic signed [D_W:0]     w_s [3];
  logic signed [D_W:0]     box_s [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r   <= '0;
      box_r[0] <= '0;
      box_r[1] <= '0;
      box_r[2] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WRAP_ENABLE: wrap_r   <= cfg_data[WRAP_W-1:0];
        CFG_BOX_LEN_X:   box_r[0] <= cfg_data[BOX_W-1:0];
        CFG_BOX_LEN_Y:   box_r[1] <= cfg_data[BOX_W-1:0];
        CFG_BOX_LEN_Z:   box_r[2] <= cfg_data[BOX_W-1:0];
        default:         wrap_r   <= wrap_r;
      endcase
    end
  end

  always_comb begin
    pos_a[0] = in_word.pos_a_x;
    pos_a[1] = in_word.pos_a_y;
    pos_a[2] = in_word.pos_a_z;
    pos_b[0] = in_word.pos_b_x;
    pos_b[1] = in_word.pos_b_y;
    pos_b[2] = in_word.pos_b_z;
    lim_s    = $signed({2'b00, in_word.rest_length, 1'b0});
    q_data.k  = in_word.stiffness;
    q_data.r0 = in_word.rest_length;
    for (int ax = 0; ax < 3; ax++) begin
      box_s[ax] = $signed({3'b000, box_r[ax]});
      v_s[ax]   = $signed({{2{pos_a[ax][POS_W-1]}}, pos_a[ax]})
                - $signed({{2{pos_b[ax][POS_W-1]}}, pos_b[ax]});
      w_s[ax]   = v_s[ax];
      if (wrap_r[ax]) begin
        if (v_s[ax] > lim_s) begin
          w_s[ax] = v_s[ax] - box_s[ax];
        end else if (v_s[ax] < -lim_s) begin
          w_s[ax] = v_s[ax] + box_s[ax];
        end
      end
      q_data.d[ax] = w_s[ax][D_W-1:0];
    end
  end

  assign q_push   = in_valid && !q_full;
  assign in_stall = q_full;

endmodule
`default_nettype wire

### hdl/hbf_fifo.sv
// Four-entry queue between the front end and the arithmetic back end.
// Depends on hbf_pkg and the core's assertion macros.
`default_nettype none
`include "harmonic_bond_force_core_macros.svh"
module hbf_fifo import hbf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  bond_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  out_valid,
  output bond_t out_data
);

  bond_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `HBF_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= QCNT_W'(QUEUE_DEPTH))
  `HBF_ASSERT_IMP(a_ptr_gap, clk, rst_n, 1'b1, (wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0])
  `HBF_ASSERT_NXT(a_count_up, clk, rst_n, do_push && !do_pop, count_r == $past(count_r) + 1'b1)
  `HBF_ASSERT_NXT(a_count_dn, clk, rst_n, do_pop && !do_push, count_r == $past(count_r) - 1'b1)

endmodule
`default_nettype wire

### hdl/hbf_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a carried bond word.
// Depends on hbf_pkg; used by hbf_back.
`default_nettype none
module hbf_sqrt import hbf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [SUM_W-1:0] in_sum,
  input  bond_t            in_side,
  output logic             out_valid,
  output logic [R_W-1:0]   out_root,
  output bond_t            out_side
);

  logic             vld_r  [R_W];
  logic [SUM_W-1:0] rem_r  [R_W];
  logic [R_W-1:0]   root_r [R_W];
  bond_t            side_r [R_W];

  for (genvar j = 0; j < R_W; j++) begin : g_step
    localparam int B = R_W - 1 - j;
    logic             vld_in;
    logic [SUM_W-1:0] rem_in;
    logic [R_W-1:0]   root_in;
    bond_t            side_in;
    logic [SUM_W:0]   trial;
    logic             take;
    logic [SUM_W-1:0] rem_nxt;
    logic [R_W-1:0]   root_nxt;

    if (j == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = in_sum;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign side_in = side_r[j-1];
    end

    assign trial    = ((SUM_W+1)'(root_in) << (B + 1)) | ((SUM_W+1)'(1) << (2 * B));
    assign take     = {1'b0, rem_in} >= trial;
    assign rem_nxt  = take ? SUM_W'({1'b0, rem_in} - trial) : rem_in;
    assign root_nxt = take ? (root_in | (R_W'(1) << B)) : root_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_in;
      end
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[R_W-1];
  assign out_root  = root_r[R_W-1];
  assign out_side  = side_r[R_W-1];

endmodule
`default_nettype wire

### hdl/hbf_div.sv
// Three-lane pipelined restoring divider with overflow detection, one quotient bit per stage.
// Depends on hbf_pkg; used by hbf_back.
`default_nettype none
module hbf_div import hbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  div_in_t  in_data,
  output logic     out_valid,
  output div_out_t out_data
);

  localparam int STAGES = Q_W + 1;

  logic                  vld_r [STAGES];
  logic [2:0][DEN_W-1:0] rem_r [STAGES];
  logic [2:0][Q_W-1:0]   lo_r  [STAGES];
  logic [DEN_W-1:0]      den_r [STAGES];
  div_out_t              res_r [STAGES];
  logic [2:0][NUM_W-1:0] upper;
  logic [2:0][DEN_W-1:0] rem0_nxt;
  logic [2:0][Q_W-1:0]   lo0_nxt;
  div_out_t              res0_nxt;

  always_comb begin
    res0_nxt.q      = '0;
    res0_nxt.kill   = in_data.kill;
    res0_nxt.neg    = in_data.neg;
    res0_nxt.energy = in_data.energy;
    for (int ax = 0; ax < 3; ax++) begin
      upper[ax]        = in_data.num[ax] >> Q_W;
      res0_nxt.ovf[ax] = upper[ax] >= NUM_W'(in_data.den);
      rem0_nxt[ax]     = upper[ax][DEN_W-1:0];
      lo0_nxt[ax]      = in_data.num[ax][Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
    if (en) begin
      rem_r[0] <= rem0_nxt;
      lo_r[0]  <= lo0_nxt;
      den_r[0] <= in_data.den;
      res_r[0] <= res0_nxt;
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_step
    localparam int BIT = Q_W - s;
    logic [2:0][DEN_W-1:0] rem_nxt;
    div_out_t              res_nxt;

    always_comb begin
      logic [DEN_W:0] part;
      res_nxt = res_r[s-1];
      for (int ax = 0; ax < 3; ax++) begin
        part = {rem_r[s-1][ax], lo_r[s-1][ax][BIT]};
        if (part >= {1'b0, den_r[s-1]}) begin
          rem_nxt[ax]        = DEN_W'(part - {1'b0, den_r[s-1]});
          res_nxt.q[ax][BIT] = 1'b1;
        end else begin
          rem_nxt[ax] = part[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
      if (en) begin
        rem_r[s] <= rem_nxt;
        lo_r[s]  <= lo_r[s-1];
        den_r[s] <= den_r[s-1];
        res_r[s] <= res_nxt;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_data  = res_r[STAGES-1];

endmodule
`default_nettype wire

### hdl/hbf_back.sv
// Back end: squares, square root, products, division, saturation and the output register.
// Depends on hbf_pkg, hbf_sqrt and hbf_div; fed by hbf_fifo.
`default_nettype none
module hbf_back import hbf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  bond_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  function automatic logic [MAG_W-1:0] abs_d(logic [D_W-1:0] v);
    logic [D_W-1:0] n;
    n = ~v + 1'b1;
    return v[D_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  logic                      adv;
  logic [MAG_W-1:0]          q_magd [3];
  logic                      s1_vld_r;
  logic [SQ_W-1:0]           s1_sq_r [3];
  bond_t                     s1_bond_r;
  logic                      s2_vld_r;
  logic [SUM_W-1:0]          s2_sum_r;
  bond_t                     s2_bond_r;
  logic                      sq_vld;
  logic [R_W-1:0]            sq_root;
  bond_t                     sq_bond;
  logic signed [DELTA_W-1:0] delta;
  logic [DM_W-1:0]           dmag;
  logic [MAG_W-1:0]          magd [3];
  logic [2:0]                kill;
  logic [2:0]                neg;
  logic                      m1_vld_r;
  logic [P1_W-1:0]           m1_p1_r;
  logic [E1_W-1:0]           m1_e1_r;
  logic [MAG_W-1:0]          m1_magd_r [3];
  logic [K_W-1:0]            m1_k_r;
  logic [DEN_W-1:0]          m1_den_r;
  logic [2:0]                m1_kill_r;
  logic [2:0]                m1_neg_r;
  logic                      m2_vld_r;
  logic [PPLO_W-1:0]         m2_pplo_r [3];
  logic [PPHI_W-1:0]         m2_pphi_r [3];
  logic [ELO_W-1:0]          m2_elo_r;
  logic [EHI_W-1:0]          m2_ehi_r;
  logic [DEN_W-1:0]          m2_den_r;
  logic [2:0]                m2_kill_r;
  logic [2:0]                m2_neg_r;
  logic [EFULL_W-1:0]        efull;
  logic [EFULL_W-1:0]        eshift;
  logic                      m3_vld_r;
  div_in_t                   m3_div_r;
  div_in_t                   m3_div_nxt;
  logic                      dv_vld;
  div_out_t                  dv_data;
  logic [OUT_W-1:0]          force_v [3];
  logic                      out_valid_r;
  out_word_t                 out_word_r;
  out_word_t                 out_word_nxt;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      q_magd[ax] = abs_d(q_data.d[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= q_valid;
      s2_vld_r <= s1_vld_r;
    end
    if (adv) begin
      for (int ax = 0; ax < 3; ax++) begin
        s1_sq_r[ax] <= SQ_W'(q_magd[ax]) * SQ_W'(q_magd[ax]);
      end
      s1_bond_r <= q_data;
      s2_sum_r  <= SUM_W'(s1_sq_r[0]) + SUM_W'(s1_sq_r[1]) + SUM_W'(s1_sq_r[2]);
      s2_bond_r <= s1_bond_r;
    end
  end

  hbf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s2_vld_r),
    .in_sum    (s2_sum_r),
    .in_side   (s2_bond_r),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_side  (sq_bond)
  );

  always_comb begin
    logic signed [DELTA_W-1:0] ndelta;
    delta  = $signed({1'b0, sq_root}) - $signed({{(DELTA_W-R0_W){1'b0}}, sq_bond.r0});
    ndelta = -delta;
    dmag   = delta[DELTA_W-1] ? ndelta[DM_W-1:0] : delta[DM_W-1:0];
    for (int ax = 0; ax < 3; ax++) begin
      magd[ax] = abs_d(sq_bond.d[ax]);
      kill[ax] = (sq_root == '0) || (delta == '0) || (sq_bond.d[ax] == '0);
      neg[ax]  = (delta[DELTA_W-1] == sq_bond.d[ax][D_W-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (adv) begin
      m1_vld_r <= sq_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
    if (adv) begin
      m1_p1_r   <= P1_W'(sq_bond.k) * P1_W'(dmag);
      m1_e1_r   <= E1_W'(dmag) * E1_W'(dmag);
      m1_magd_r <= magd;
      m1_k_r    <= sq_bond.k;
      m1_den_r  <= {sq_root, {FRAC_BITS{1'b0}}};
      m1_kill_r <= kill;
      m1_neg_r  <= neg;
      for (int ax = 0; ax < 3; ax++) begin
        m2_pplo_r[ax] <= PPLO_W'(m1_p1_r[P1_LO_W-1:0]) * PPLO_W'(m1_magd_r[ax]);
        m2_pphi_r[ax] <= PPHI_W'(m1_p1_r[P1_W-1:P1_LO_W]) * PPHI_W'(m1_magd_r[ax]);
      end
      m2_elo_r  <= ELO_W'(m1_e1_r[E1_LO_W-1:0]) * ELO_W'(m1_k_r);
      m2_ehi_r  <= EHI_W'(m1_e1_r[E1_W-1:E1_LO_W]) * EHI_W'(m1_k_r);
      m2_den_r  <= m1_den_r;
      m2_kill_r <= m1_kill_r;
      m2_neg_r  <= m1_neg_r;
      m3_div_r  <= m3_div_nxt;
    end
  end

  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      m3_div_nxt.num[ax] = ((NUM_W'(m2_pphi_r[ax]) << P1_LO_W) + NUM_W'(m2_pplo_r[ax])) << 1;
    end
    m3_div_nxt.den  = m2_den_r;
    m3_div_nxt.kill = m2_kill_r;
    m3_div_nxt.neg  = m2_neg_r;
    efull  = (EFULL_W'(m2_ehi_r) << E1_LO_W) + EFULL_W'(m2_elo_r);
    eshift = efull >> (2 * FRAC_BITS);
    m3_div_nxt.energy = (|eshift[EFULL_W-1:OUT_W]) ? {OUT_W{1'b1}} : eshift[OUT_W-1:0];
  end

  hbf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (m3_vld_r),
    .in_data   (m3_div_r),
    .out_valid (dv_vld),
    .out_data  (dv_data)
  );

  always_comb begin
    logic [OUT_W-1:0] cap;
    logic [OUT_W-1:0] qm;
    for (int ax = 0; ax < 3; ax++) begin
      cap = dv_data.neg[ax] ? FORCE_NEG_CAP : FORCE_POS_CAP;
      qm  = (dv_data.ovf[ax] || (dv_data.q[ax] > cap)) ? cap : dv_data.q[ax];
      if (dv_data.kill[ax]) begin
        force_v[ax] = '0;
      end else begin
        force_v[ax] = dv_data.neg[ax] ? (~qm + 1'b1) : qm;
      end
    end
    out_word_nxt.force_x     = force_v[0];
    out_word_nxt.force_y     = force_v[1];
    out_word_nxt.force_z     = force_v[2];
    out_word_nxt.energy_term = dv_data.energy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld;
    end
    if (adv) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

### hdl/harmonic_bond_force_core.sv
// Top level of the harmonic bond force core: front end, queue and arithmetic back end.
// Depends on hbf_pkg, hbf_front, hbf_fifo and hbf_back.
//
//   channel  direction  handshake               word
//   in_      input      in_valid / in_stall     in_word_t: two positions, k, r0
//   out_     output     out_valid / out_stall   out_word_t: force x, y, z and energy
//   cfg_     input      cfg_wr_en               cfg_index selects, cfg_data carries
//
// One word is accepted per cycle while the four-entry queue has room.
// A word passes the queue, the square and sum registers, the 33-step square root
// pipeline, the product registers, the 49-step divider pipeline and output register.
// Reset clears the configuration registers, empties the queue and drops words in flight.
// A stalled valid output holds the whole back end; the queue keeps accepting until full.
`default_nettype none
module harmonic_bond_force_core import hbf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic  q_full;
  logic  q_push;
  bond_t q_wdata;
  logic  q_pop;
  logic  q_valid;
  bond_t q_rdata;

  hbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  hbf_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .out_valid (q_valid),
    .out_data  (q_rdata)
  );

  hbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench of harmonic_bond_force_core: bonds are driven through the input
// channel and each result word is compared against an in-bench force and energy predictor.
// Depends on hbf_pkg and harmonic_bond_force_core only.
`default_nettype none
module tb_top;
  import hbf_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_word;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  harmonic_bond_force_core dut (.*);

  logic [WRAP_W-1:0] wrap_bits;
  logic [BOX_W-1:0]  box_len [3];

  in_word_t  bond_queue[$];
  out_word_t pending_forces[$];
  bit        hold;
  int        gap_left;
  int        burst_left;
  int        stall_mode;
  int        mismatches;
  int        results_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("[harmonic_bond_force_core] ERROR");
    $finish;
  end

  function automatic logic [63:0] mag64(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic out_word_t bond_force(in_word_t w);
    longint       d [3];
    longint       lim;
    longint       delta;
    logic [127:0] sum;
    logic [127:0] cand;
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] e;
    logic [63:0]  r;
    logic [63:0]  dmag;
    logic [63:0]  cap;
    logic [63:0]  qm;
    logic [63:0]  f [3];
    bit           neg;
    out_word_t    o;
    d[0] = longint'(w.pos_a_x) - longint'(w.pos_b_x);
    d[1] = longint'(w.pos_a_y) - longint'(w.pos_b_y);
    d[2] = longint'(w.pos_a_z) - longint'(w.pos_b_z);
    lim = 2 * longint'({33'd0, w.rest_length});
    sum = '0;
    for (int ax = 0; ax < 3; ax++) begin
      if (wrap_bits[ax]) begin
        if (d[ax] > lim) d[ax] = d[ax] - longint'({33'd0, box_len[ax]});
        else if (d[ax] < -lim) d[ax] = d[ax] + longint'({33'd0, box_len[ax]});
      end
      sum = sum + 128'(mag64(d[ax])) * 128'(mag64(d[ax]));
    end
    r = '0;
    for (int b = 36; b >= 0; b--) begin
      cand = 128'(r | (64'd1 << b));
      if (cand * cand <= sum) r = cand[63:0];
    end
    delta = longint'(r) - longint'({33'd0, w.rest_length});
    dmag = mag64(delta);
    for (int ax = 0; ax < 3; ax++) begin
      f[ax] = '0;
      if (r != 0 && delta != 0 && d[ax] != 0) begin
        num = 128'(w.stiffness) * 128'(dmag) * 128'(mag64(d[ax]));
        num = num << 1;
        q = num / (128'(r) << FRAC_BITS);
        neg = (delta < 0) == (d[ax] < 0);
        cap = neg ? (64'd1 << 47) : ((64'd1 << 47) - 1);
        qm = (q > 128'(cap)) ? cap : q[63:0];
        f[ax] = neg ? -qm : qm;
      end
    end
    e = (128'(dmag) * 128'(dmag) * 128'(w.stiffness)) >> (2 * FRAC_BITS);
    o.force_x = f[0][OUT_W-1:0];
    o.force_y = f[1][OUT_W-1:0];
    o.force_z = f[2][OUT_W-1:0];
    o.energy_term = (e > 128'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
    return o;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    bit taken;
    bit nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 8;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) pending_forces.push_back(bond_force(in_word));
      if (!in_valid || taken) begin
        nv = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (bond_queue.size() > 0 && !hold) begin
          in_word <= bond_queue.pop_front();
          nv = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        in_valid <= nv;
      end
    end
  end

  // Receiver: the stall pattern is redrawn at random moments from four modes.
  always @(posedge clk) begin
    int cyc;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      cyc = $urandom_range(0, 255);
      if (cyc == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_forces.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h", out_word);
      end else begin
        want = pending_forces.pop_front();
        if (want.force_x !== out_word.force_x || want.force_y !== out_word.force_y ||
            want.force_z !== out_word.force_z || want.energy_term !== out_word.energy_term) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected f=(%h %h %h) e=%h, got f=(%h %h %h) e=%h",
                     want.force_x, want.force_y, want.force_z, want.energy_term,
                     out_word.force_x, out_word.force_y, out_word.force_z,
                     out_word.energy_term);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WRAP_ENABLE: wrap_bits = val[WRAP_W-1:0];
      CFG_BOX_LEN_X:   box_len[0] = val;
      CFG_BOX_LEN_Y:   box_len[1] = val;
      default:         box_len[2] = val;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain;
    while (bond_queue.size() > 0 || in_valid || pending_forces.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_word_t bond_of(logic [31:0] ax, ay, az, bx, by, bz,
                                       logic [31:0] k, logic [30:0] r0);
    in_word_t w;
    w.pos_a_x = ax; w.pos_a_y = ay; w.pos_a_z = az;
    w.pos_b_x = bx; w.pos_b_y = by; w.pos_b_z = bz;
    w.stiffness = k;
    w.rest_length = r0;
    return w;
  endfunction

  // Mostly physical bonds (small separation near r0), some fully random words.
  function automatic in_word_t random_bond(int span);
    in_word_t w;
    logic [31:0] base [3];
    int          off [3];
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         31'($urandom)};
    if ($urandom_range(0, 4) != 0) begin
      for (int i = 0; i < 3; i++) begin
        base[i] = $urandom;
        off[i] = $urandom_range(0, 2 * span) - span;
      end
      w = bond_of(base[0], base[1], base[2], base[0] - off[0], base[1] - off[1],
                  base[2] - off[2], $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22),
                  31'($urandom_range(0, span)));
    end
    return w;
  endfunction

  initial begin
    logic [31:0] mx;
    logic [31:0] mn;
    logic [30:0] r0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_WRAP_ENABLE;
    cfg_data = '0;
    hold = 1'b0;
    mismatches = 0;
    results_seen = 0;
    wrap_bits = '0;
    box_len[0] = '0; box_len[1] = '0; box_len[2] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    r0 = 31'h7FFF_FFFF;
    bond_queue.push_back(bond_of(0, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000));
    bond_queue.push_back(bond_of(5, 5, 5, 5, 5, 5, '1, r0));
    bond_queue.push_back(bond_of(mx, mx, mx, mn, mn, mn, '1, 31'd0));
    bond_queue.push_back(bond_of(mn, mn, mn, mx, mx, mx, '1, r0));
    bond_queue.push_back(bond_of(mx, 0, 0, mn, 0, 0, 32'h0001_0000, 31'd0));
    bond_queue.push_back(bond_of(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0,
                                 32'h0002_0000, 31'h0005_0000));
    bond_queue.push_back(bond_of(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0,
                                 32'h0002_0000, 31'h0004_0000));
    bond_queue.push_back(bond_of(0, 0, 32'h0001_0000, 0, 0, 0, 0, 31'h0000_8000));
    bond_queue.push_back(bond_of(1, 0, 0, 0, 0, 0, '1, 31'd0));
    bond_queue.push_back(bond_of(0, mn, 0, 0, mx, 0, 32'h8000_0000, 31'h4000_0000));
    drain();

    write_reg(CFG_WRAP_ENABLE, 31'd7);
    write_reg(CFG_BOX_LEN_X, 31'h7FFF_FFFF);
    write_reg(CFG_BOX_LEN_Y, 31'd0);
    write_reg(CFG_BOX_LEN_Z, 31'($urandom));
    bond_queue.push_back(bond_of(32'h0002_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000));
    bond_queue.push_back(bond_of(32'h0002_0001, 0, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000));
    bond_queue.push_back(bond_of(0, 32'h0002_0001, 0, 0, 0, 0, 32'h0001_0000, 31'h0001_0000));
    bond_queue.push_back(bond_of(0, 0, 0, 32'h0002_0001, 0, 32'h0002_0001,
                                 32'h0001_0000, 31'h0001_0000));
    bond_queue.push_back(bond_of(mx, mx, mx, mn, mn, mn, '1, r0));
    bond_queue.push_back(bond_of(mn, mx, mn, mx, mn, mx, '1, 31'd0));
    for (int i = 0; i < 400; i++)
      bond_queue.push_back(random_bond($urandom_range(0, 1) ? 1 << 18 : 1 << 30));
    drain();

    write_reg(CFG_WRAP_ENABLE, 31'd5);
    write_reg(CFG_BOX_LEN_X, 31'h000A_0000);
    write_reg(CFG_BOX_LEN_Y, 31'h0010_0000);
    write_reg(CFG_BOX_LEN_Z, 31'h0008_0000);
    for (int i = 0; i < 200; i++) bond_queue.push_back(random_bond(1 << 19));
    while (bond_queue.size() > 0) @(posedge clk);
    hold = 1'b1;
    while (in_valid || pending_forces.size() > 0) @(posedge clk);
    hold = 1'b0;
    for (int i = 0; i < 200; i++) bond_queue.push_back(random_bond(1 << 19));
    drain();

    for (int p = 0; p < 3; p++) begin
      write_reg(CFG_WRAP_ENABLE, 31'($urandom_range(0, 7)));
      write_reg(CFG_BOX_LEN_X, 31'($urandom));
      write_reg(CFG_BOX_LEN_Y, 31'($urandom_range(0, 1 << 22)));
      write_reg(CFG_BOX_LEN_Z, 31'($urandom) >> $urandom_range(0, 30));
      for (int i = 0; i < 250; i++)
        bond_queue.push_back(random_bond(1 << $urandom_range(4, 30)));
      drain();
    end

    if (mismatches == 0 && pending_forces.size() == 0) begin
      $display("[harmonic_bond_force_core] OK");
    end else begin
      $display("[harmonic_bond_force_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
